/* hw/rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: widths, action codes, request/result types.
package rau_pkg;

    localparam int OPW = 16;
    localparam int NW  = 2 * OPW;
    localparam int DW  = 2 * OPW - 1;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    typedef struct packed {
        logic [2:0]            action;
        logic signed [OPW-1:0] a_num;
        logic signed [OPW-1:0] a_den;
        logic signed [OPW-1:0] b_num;
        logic signed [OPW-1:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [NW:0] res_num;
        logic [DW-1:0]      res_den;
        logic               status;
        logic               is_less;
        logic               is_equal;
        logic               is_greater;
    } t_res;

endpackage

/* hw/rtl/rational_arithmetic_unit_top.sv */
// Rational arithmetic unit: sequenced multiply, binary GCD and restoring divide.
//
// One request is accepted when start is high and busy is low; busy stays high
// until the result is shown on o_res for one cycle with o_valid. The receiver
// cannot stall. A request takes three products of the shared 16x16 multiplier,
// an add/compare step, then a binary GCD (one shift or subtract a cycle plus a
// closing step) and two restoring divisions for a nonzero result. Zero,
// compare, error and unused actions finish after the add/compare step.
module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ALU  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIVN = 3'd4;
    localparam logic [2:0] S_DIVD = 3'd5;

    localparam int KW = $clog2(NW + 1);
    localparam int CW = $clog2(NW);

    logic [2:0]     r_state;
    logic [2:0]     r_act;
    logic           r_err;
    logic [OPW-1:0] r_man, r_mad, r_mbn, r_mbd;
    logic           r_s0, r_s1, r_s2;
    logic [1:0]     r_mcnt;
    logic [NW-1:0]  r_p0, r_p1, r_p2;
    logic [NW-1:0]  r_nm, r_dm;
    logic           r_neg;
    logic [NW-1:0]  r_x, r_y;
    logic [KW-1:0]  r_k;
    logic [NW-1:0]  r_g;
    logic [NW-1:0]  r_dvd;
    logic [NW:0]    r_rem;
    logic [CW-1:0]  r_cnt;
    logic [NW-1:0]  r_qn;
    logic           r_valid;
    t_res           r_res;

    function automatic logic [OPW-1:0] f_mag(input logic [OPW-1:0] v);
        return v[OPW-1] ? (~v + OPW'(1)) : v;
    endfunction

    // shared multiplier
    logic [OPW-1:0] mul_a, mul_b;
    logic [NW-1:0]  mul_p;
    always_comb begin
        mul_a = r_man;
        mul_b = r_mbd;
        case (r_mcnt)
            2'd0: begin
                mul_a = r_man;
                mul_b = (r_act == ACT_MUL) ? r_mbn : r_mbd;
            end
            2'd1: begin
                mul_a = r_mbn;
                mul_b = r_mad;
            end
            default: begin
                mul_a = r_mad;
                mul_b = (r_act == ACT_DIV) ? r_mbn : r_mbd;
            end
        endcase
        mul_p = NW'(mul_a) * NW'(mul_b);
    end

    // add / compare step
    logic signed [NW:0] p_s, q_s, sum_s;
    logic [NW-1:0]      sum_m;
    logic               cmp_lt, cmp_gt;
    always_comb begin
        p_s   = r_s0 ? -$signed({1'b0, r_p0}) : $signed({1'b0, r_p0});
        q_s   = r_s1 ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
        sum_s = (r_act == ACT_SUB) ? (p_s - q_s) : (p_s + q_s);
        sum_m = sum_s[NW] ? NW'(-sum_s) : NW'(sum_s);
        // denominator product sign flips the order
        cmp_lt = r_s2 ? (p_s > q_s) : (p_s < q_s);
        cmp_gt = r_s2 ? (p_s < q_s) : (p_s > q_s);
    end

    // restoring divider step
    logic [NW:0] rem_sh;
    logic        rem_ge;
    always_comb begin
        rem_sh = {r_rem[NW-1:0], r_dvd[NW-1]};
        rem_ge = rem_sh >= {1'b0, r_g};
    end

    logic [NW:0] qn_s;
    assign qn_s = r_neg ? -$signed({1'b0, r_qn}) : $signed({1'b0, r_qn});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_act  <= i_req.action;
                        r_err  <= (i_req.action <= ACT_CMP)
                                  && (i_req.a_den == '0 || i_req.b_den == '0
                                      || (i_req.action == ACT_DIV && i_req.b_num == '0));
                        r_man  <= f_mag(i_req.a_num);
                        r_mad  <= f_mag(i_req.a_den);
                        r_mbn  <= f_mag(i_req.b_num);
                        r_mbd  <= f_mag(i_req.b_den);
                        r_s0   <= i_req.a_num[OPW-1] ^ ((i_req.action == ACT_MUL)
                                  ? i_req.b_num[OPW-1] : i_req.b_den[OPW-1]);
                        r_s1   <= i_req.b_num[OPW-1] ^ i_req.a_den[OPW-1];
                        r_s2   <= i_req.a_den[OPW-1] ^ ((i_req.action == ACT_DIV)
                                  ? i_req.b_num[OPW-1] : i_req.b_den[OPW-1]);
                        r_mcnt <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_mcnt)
                        2'd0:    r_p0 <= mul_p;
                        2'd1:    r_p1 <= mul_p;
                        default: r_p2 <= mul_p;
                    endcase
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd2) begin
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    r_dm <= r_p2;
                    if (r_act == ACT_ADD || r_act == ACT_SUB) begin
                        r_nm  <= sum_m;
                        r_x   <= sum_m;
                        r_neg <= sum_s[NW] ^ r_s2;
                    end else begin
                        r_nm  <= r_p0;
                        r_x   <= r_p0;
                        r_neg <= r_s0 ^ r_s2;
                    end
                    r_y <= r_p2;
                    r_k <= '0;
                    if (r_err || r_act > ACT_DIV
                            || ((r_act == ACT_ADD || r_act == ACT_SUB) && sum_m == '0)
                            || ((r_act == ACT_MUL || r_act == ACT_DIV) && r_p0 == '0)) begin
                        r_res.res_num    <= '0;
                        r_res.res_den    <= DW'(1);
                        r_res.status     <= r_err;
                        r_res.is_less    <= !r_err && r_act == ACT_CMP && cmp_lt;
                        r_res.is_greater <= !r_err && r_act == ACT_CMP && cmp_gt;
                        r_res.is_equal   <= !r_err && r_act == ACT_CMP && !cmp_lt && !cmp_gt;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    // binary GCD, one step a cycle
                    if (r_x == '0 || r_y == '0) begin
                        r_g     <= ((r_x == '0) ? r_y : r_x) << r_k;
                        r_dvd   <= r_nm;
                        r_rem   <= '0;
                        r_cnt   <= CW'(NW - 1);
                        r_state <= S_DIVN;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= r_x - r_y;
                    end else begin
                        r_y <= r_y - r_x;
                    end
                end
                S_DIVN, S_DIVD: begin
                    r_rem <= rem_ge ? (rem_sh - {1'b0, r_g}) : rem_sh;
                    r_dvd <= {r_dvd[NW-2:0], rem_ge};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        if (r_state == S_DIVN) begin
                            r_qn    <= {r_dvd[NW-2:0], rem_ge};
                            r_dvd   <= r_dm;
                            r_rem   <= '0;
                            r_cnt   <= CW'(NW - 1);
                            r_state <= S_DIVD;
                        end else begin
                            r_res.res_num    <= qn_s;
                            r_res.res_den    <= DW'({r_dvd[NW-2:0], rem_ge});
                            r_res.status     <= 1'b0;
                            r_res.is_less    <= 1'b0;
                            r_res.is_equal   <= 1'b0;
                            r_res.is_greater <= 1'b0;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef NO_ASSERTIONS
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result shown while busy");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status) |-> (o_res.res_num == '0 && o_res.res_den == DW'(1)))
        else $error("error result not 0/1");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.res_den != '0)) else $error("zero denominator");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_res.is_less, o_res.is_equal, o_res.is_greater}) <= 1)
        else $error("more than one compare flag");
`endif

endmodule

/* test/tb_rational_arithmetic_unit_top.sv */
// Testbench for the rational arithmetic unit: random and corner requests checked by a predictor.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit_top;
    import rau_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_valid;
    t_res o_res;

    rational_arithmetic_unit_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   n_mismatch;
    int   gap_left;
    bit   gaps_on;
    bit   drain_hold;
    bit   stim_done;
    logic accepted;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic t_res reduce_fraction(t_req q);
        t_res r;
        longint an, ad, bn, bd, p, s;
        longint unsigned nm, dm, g, pm, sm;
        bit nneg, dneg, pn, sn;
        int d;
        an = q.a_num; ad = q.a_den; bn = q.b_num; bd = q.b_den;
        nneg = 0; dneg = 0; nm = 0; dm = 1;
        r = '0;
        if (q.action <= ACT_CMP && (ad == 0 || bd == 0)) begin
            r.status = 1'b1;
        end else if (q.action == ACT_ADD || q.action == ACT_SUB) begin
            p = an * bd;
            s = bn * ad;
            pn = p < 0;
            sn = (s < 0) != (q.action == ACT_SUB);
            pm = magnitude(p);
            sm = magnitude(s);
            if (pn == sn) begin
                nneg = pn; nm = pm + sm;
            end else if (pm >= sm) begin
                nneg = pn; nm = pm - sm;
            end else begin
                nneg = sn; nm = sm - pm;
            end
            dneg = (ad < 0) != (bd < 0);
            dm = magnitude(ad) * magnitude(bd);
        end else if (q.action == ACT_MUL) begin
            nneg = (an < 0) != (bn < 0);
            nm = magnitude(an) * magnitude(bn);
            dneg = (ad < 0) != (bd < 0);
            dm = magnitude(ad) * magnitude(bd);
        end else if (q.action == ACT_DIV) begin
            if (bn == 0) begin
                r.status = 1'b1;
            end else begin
                nneg = (an < 0) != (bd < 0);
                nm = magnitude(an) * magnitude(bd);
                dneg = (ad < 0) != (bn < 0);
                dm = magnitude(ad) * magnitude(bn);
            end
        end else if (q.action == ACT_CMP) begin
            p = an * bd;
            s = bn * ad;
            d = (p > s) ? 1 : ((p < s) ? -1 : 0);
            if ((ad < 0) != (bd < 0)) d = -d;
            r.is_less = d < 0;
            r.is_equal = d == 0;
            r.is_greater = d > 0;
        end
        if (nm == 0) begin
            nneg = 0; dneg = 0; dm = 1;
        end else begin
            g = euclid_gcd(nm, dm);
            nm = nm / g;
            dm = dm / g;
        end
        r.res_num = (NW + 1)'((nneg != dneg) ? -nm : nm);
        r.res_den = DW'(dm);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        n_mismatch++;
    endtask

    function automatic logic [15:0] pick_operand(bit nonzero);
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = 16'hffff;
            3: v = 16'(signed'($urandom_range(0, 16)) - 8);
            4: v = 16'($urandom_range(1, 255));
            default: v = 16'($urandom);
        endcase
        if (nonzero && v == 0) v = 16'd1;
        return v;
    endfunction

    // accept tracking: one request per accept
    always @(posedge i_clk) begin
        accepted = i_rst_n && start && !busy;
        if (accepted) begin
            expected_results.push_back(reduce_fraction(i_req));
            void'(pending_reqs.pop_front());
        end
    end

    // driver: random bursts of idle cycles
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !accepted) begin
                // hold the request until it is taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                gap_left <= $urandom_range(1, 18) - 1;
                start <= 1'b0;
            end else if (drain_hold && expected_results.size() != 0) begin
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                i_req <= pending_reqs[0];
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_res.res_num, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_res.res_num !== want.res_num)
                    report_mismatch("res_num", o_res.res_num, want.res_num);
                if (o_res.res_den !== want.res_den)
                    report_mismatch("res_den", o_res.res_den, want.res_den);
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
                if (o_res.is_less !== want.is_less)
                    report_mismatch("is_less", o_res.is_less, want.is_less);
                if (o_res.is_equal !== want.is_equal)
                    report_mismatch("is_equal", o_res.is_equal, want.is_equal);
                if (o_res.is_greater !== want.is_greater)
                    report_mismatch("is_greater", o_res.is_greater, want.is_greater);
            end
        end
    end

    task automatic add_request(logic [2:0] act, logic [15:0] an, logic [15:0] ad,
                               logic [15:0] bn, logic [15:0] bd);
        t_req q;
        q.action = act; q.a_num = an; q.a_den = ad; q.b_num = bn; q.b_den = bd;
        pending_reqs.push_back(q);
    endtask

    initial begin
        t_req q;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        gap_left = 0;
        gaps_on = 1'b0;
        drain_hold = 1'b0;
        n_mismatch = 0;
        accepted = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_request(ACT_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        add_request(ACT_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        add_request(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_request(ACT_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h0001);
        add_request(ACT_ADD, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
        add_request(ACT_SUB, 16'h7fff, 16'hffff, 16'h8000, 16'h7fff);
        add_request(ACT_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
        add_request(ACT_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        add_request(ACT_DIV, 16'hffff, 16'h8000, 16'hffff, 16'h7fff);
        add_request(ACT_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
        add_request(ACT_CMP, 16'd1, 16'hfffe, 16'd1, 16'd3);
        add_request(ACT_CMP, 16'h7fff, 16'd1, 16'h8000, 16'hffff);
        add_request(ACT_CMP, 16'd2, 16'hfffd, 16'd1, 16'd3);
        add_request(ACT_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
        add_request(ACT_CMP, 16'd1, 16'd1, 16'd1, 16'd0);
        add_request(ACT_DIV, 16'd1, 16'd0, 16'd0, 16'd1);
        add_request(3'd5, 16'd7, 16'd3, 16'd1, 16'd1);
        add_request(3'd6, 16'd1, 16'd0, 16'd1, 16'd0);
        add_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_request(ACT_MUL, 16'd0, 16'hffff, 16'd5, 16'd7);
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);

        gaps_on = 1'b1;
        for (int i = 0; i < 1330; i++) begin
            q.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
            q.a_num = pick_operand(1'b0);
            q.b_num = pick_operand($urandom_range(0, 15) != 0);
            q.a_den = pick_operand($urandom_range(0, 19) != 0);
            q.b_den = pick_operand($urandom_range(0, 19) != 0);
            if (q.action == ACT_CMP && $urandom_range(0, 3) == 0) begin
                // copy of operand a, hits equality
                q.b_num = q.a_num * 16'sd1;
                q.b_den = q.a_den;
            end
            pending_reqs.push_back(q);
            if (i == 400) begin
                wait (pending_reqs.size() == 0);
                drain_hold = 1'b1;
                wait (expected_results.size() == 0);
                drain_hold = 1'b0;
            end
            if (i == 1100) begin
                wait (pending_reqs.size() == 0);
                gaps_on = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
